>>> hw/rtl/bdq_pkg.sv
// Shared types, codes and defaults for the byte deque with palindrome check.
`timescale 1ns / 1ps

package bdq_pkg;

  // Default number of slots in the circular store (holds DEPTH-1 entries)
  localparam int DEPTH_DEF = 128;

  // Operation codes
  localparam logic [2:0] OP_ADD_REAR  = 3'd0;
  localparam logic [2:0] OP_ADD_FRONT = 3'd1;
  localparam logic [2:0] OP_REM_FRONT = 3'd2;
  localparam logic [2:0] OP_REM_REAR  = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_PAL_CHECK = 3'd5;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Byte returned by a remove from an empty queue
  localparam logic [7:0] EMPTY_BYTE = 8'hFF;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [1:0] status;
    logic       palindrome_flag;
    logic [6:0] fill_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_PAL_A,
    ST_PAL_B,
    ST_PAL_C,
    ST_PAL_DONE
  } state_t;

endpackage

>>> hw/rtl/bdq_in_if.sv
// Valid/ready channel carrying one deque operation.
`timescale 1ns / 1ps

interface bdq_in_if;
  logic              valid;
  logic              ready;
  bdq_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/bdq_out_if.sv
// Valid/ready channel carrying one deque result.
`timescale 1ns / 1ps

interface bdq_out_if;
  logic               valid;
  logic               ready;
  bdq_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/byte_deque_with_palindrome_check_unit.sv
// Byte deque with palindrome check: top level with store, sequencer and output register.
`timescale 1ns / 1ps

// Circular double-ended byte queue of DEPTH slots holding up to DEPTH-1 entries,
// one operation in and one result out per transfer. Add rear/front, clear, undefined
// codes and any operation that is rejected (push when full, remove when empty) finish
// in the accept cycle, so they sustain one per cycle while the receiver takes results.
// A remove that returns data goes through ST_POP: the store has a single registered
// read port. The palindrome check walks inward from both ends through that same read
// port, one step per pass through ST_PAL_A, ST_PAL_B, ST_PAL_C (read low end, read high
// end, compare). A step retires one or two bytes and the walk stops at a mismatch or
// with at most one byte left. The block takes no new operation until the check is
// done. A finished result sits in an output register, and the next operation is taken
// in the same cycle the waiting result transfers.
// Store contents are not cleared at reset or by a clear operation.
module byte_deque_with_palindrome_check_unit #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bdq_in_if.sink           in_if,
  bdq_out_if.source        out_if
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  // index helpers, wrap at DEPTH (need not be a power of two)
  function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  // entries held: (t - h) mod DEPTH, reported in 7 bits
  function automatic logic [6:0] fill_of(input logic [IW-1:0] h, input logic [IW-1:0] t);
    logic [IW:0] diff;
    if (t >= h) diff = {1'b0, t} - {1'b0, h};
    else        diff = {1'b0, t} + (IW+1)'(DEPTH) - {1'b0, h};
    return 7'(diff);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  // on a folded byte: digit or lower-case letter
  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // ---------------------------------------------------------------------------
  // state
  bdq_pkg::state_t    state_r, state_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [IW-1:0]      tail_r, tail_nxt;
  logic [IW-1:0]      lo_r, lo_nxt;      // palindrome walk, low end (empty slot before)
  logic [IW-1:0]      hi_r, hi_nxt;      // palindrome walk, high end
  logic [7:0]         a_r, a_nxt;        // folded low-end byte
  logic               pal_r, pal_nxt;
  logic               out_valid_r, out_valid_nxt;
  bdq_pkg::out_item_t out_data_r, out_data_nxt;

  // store
  logic [7:0]         mem [DEPTH];
  logic [7:0]         rd_q;
  logic               wr_en, rd_en;
  logic [IW-1:0]      wr_addr, rd_addr;
  logic [7:0]         wr_data;

  logic slot_free, accept, empty, full;
  logic [7:0] b_fold;

  assign slot_free = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == bdq_pkg::ST_IDLE) && slot_free;
  assign accept = in_if.valid && in_if.ready;
  assign empty = (head_r == tail_r);
  assign full  = (idx_next(tail_r) == head_r);
  assign b_fold = fold_case(rd_q);

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // ---------------------------------------------------------------------------
  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdq_pkg::ST_IDLE: begin
        if (accept) begin
          if ((in_if.data.operation == bdq_pkg::OP_REM_FRONT ||
               in_if.data.operation == bdq_pkg::OP_REM_REAR) && !empty) begin
            state_nxt = bdq_pkg::ST_POP;
          end else if (in_if.data.operation == bdq_pkg::OP_PAL_CHECK) begin
            state_nxt = bdq_pkg::ST_PAL_A;
          end
        end
      end
      bdq_pkg::ST_POP: begin
        if (slot_free) state_nxt = bdq_pkg::ST_IDLE;
      end
      bdq_pkg::ST_PAL_A: begin
        if (lo_r == hi_r || idx_next(lo_r) == hi_r) state_nxt = bdq_pkg::ST_PAL_DONE;
        else                                         state_nxt = bdq_pkg::ST_PAL_B;
      end
      bdq_pkg::ST_PAL_B: state_nxt = bdq_pkg::ST_PAL_C;
      bdq_pkg::ST_PAL_C: begin
        if (is_alnum(a_r) && is_alnum(b_fold) && a_r != b_fold) begin
          state_nxt = bdq_pkg::ST_PAL_DONE;
        end else begin
          state_nxt = bdq_pkg::ST_PAL_A;
        end
      end
      bdq_pkg::ST_PAL_DONE: begin
        if (slot_free) state_nxt = bdq_pkg::ST_IDLE;
      end
      default: state_nxt = bdq_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath and outputs
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    a_nxt        = a_r;
    pal_nxt      = pal_r;
    out_data_nxt = out_data_r;
    wr_en        = 1'b0;
    wr_addr      = head_r;
    wr_data      = in_if.data.data_byte;
    rd_en        = 1'b0;
    rd_addr      = tail_r;
    out_valid_nxt = out_valid_r && !out_if.ready;

    unique case (state_r)
      bdq_pkg::ST_IDLE: begin
        if (accept) begin
          // default result; overwritten below where needed
          out_data_nxt.read_byte       = 8'd0;
          out_data_nxt.status          = bdq_pkg::STAT_OK;
          out_data_nxt.palindrome_flag = 1'b0;
          out_valid_nxt = 1'b1;
          case (in_if.data.operation)
            bdq_pkg::OP_ADD_REAR: begin
              if (full) begin
                out_data_nxt.status = bdq_pkg::STAT_FULL;
              end else begin
                tail_nxt = idx_next(tail_r);
                wr_en    = 1'b1;
                wr_addr  = idx_next(tail_r);
              end
            end
            bdq_pkg::OP_ADD_FRONT: begin
              if (full) begin
                out_data_nxt.status = bdq_pkg::STAT_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = head_r;
                head_nxt = idx_prev(head_r);
              end
            end
            bdq_pkg::OP_REM_FRONT: begin
              if (empty) begin
                out_data_nxt.read_byte = bdq_pkg::EMPTY_BYTE;
                out_data_nxt.status    = bdq_pkg::STAT_EMPTY;
              end else begin
                head_nxt      = idx_next(head_r);
                rd_en         = 1'b1;
                rd_addr       = idx_next(head_r);
                out_valid_nxt = out_valid_r && !out_if.ready;
              end
            end
            bdq_pkg::OP_REM_REAR: begin
              if (empty) begin
                out_data_nxt.read_byte = bdq_pkg::EMPTY_BYTE;
                out_data_nxt.status    = bdq_pkg::STAT_EMPTY;
              end else begin
                tail_nxt      = idx_prev(tail_r);
                rd_en         = 1'b1;
                rd_addr       = tail_r;
                out_valid_nxt = out_valid_r && !out_if.ready;
              end
            end
            bdq_pkg::OP_CLEAR: begin
              head_nxt = '0;
              tail_nxt = '0;
            end
            bdq_pkg::OP_PAL_CHECK: begin
              lo_nxt        = head_r;
              hi_nxt        = tail_r;
              out_valid_nxt = out_valid_r && !out_if.ready;
            end
            default: ;  // undefined codes: no effect
          endcase
          out_data_nxt.fill_count = fill_of(head_nxt, tail_nxt);
          // a deferred result keeps the waiting output intact
          if (!out_valid_nxt || (out_valid_r && !out_if.ready)) begin
            out_data_nxt = out_data_r;
          end
        end
      end
      bdq_pkg::ST_POP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.read_byte       = rd_q;
          out_data_nxt.status          = bdq_pkg::STAT_OK;
          out_data_nxt.palindrome_flag = 1'b0;
          out_data_nxt.fill_count      = fill_of(head_r, tail_r);
        end
      end
      bdq_pkg::ST_PAL_A: begin
        if (lo_r == hi_r || idx_next(lo_r) == hi_r) begin
          pal_nxt = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_next(lo_r);
        end
      end
      bdq_pkg::ST_PAL_B: begin
        a_nxt   = fold_case(rd_q);
        rd_en   = 1'b1;
        rd_addr = hi_r;
      end
      bdq_pkg::ST_PAL_C: begin
        if (!is_alnum(a_r)) begin
          lo_nxt = idx_next(lo_r);
        end else if (!is_alnum(b_fold)) begin
          hi_nxt = idx_prev(hi_r);
        end else if (a_r != b_fold) begin
          pal_nxt = 1'b0;
        end else begin
          lo_nxt = idx_next(lo_r);
          hi_nxt = idx_prev(hi_r);
        end
      end
      bdq_pkg::ST_PAL_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.read_byte       = 8'd0;
          out_data_nxt.status          = bdq_pkg::STAT_OK;
          out_data_nxt.palindrome_flag = pal_r;
          out_data_nxt.fill_count      = fill_of(head_r, tail_r);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdq_pkg::ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    a_r        <= a_nxt;
    pal_r      <= pal_nxt;
    out_data_r <= out_data_nxt;
  end

  // byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

endmodule

>>> tb/byte_deque_with_palindrome_check_unit_test.sv
// Self-checking testbench for the byte deque with palindrome check.
`timescale 1ns / 1ps

module byte_deque_with_palindrome_check_unit_test;

  localparam int QD           = bdq_pkg::DEPTH_DEF;  // slots; QD-1 entries max
  localparam int TOTAL_ITEMS  = 525;        // counted transfers; 6/7 codes come on top
  localparam int HOLD_CYCLES  = 300;        // long receiver stall
  localparam int SETTLE_CYCLES = 400;       // longer than the worst check walk
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int NUM_ROWS     = 25;

  // Codes with no meaning in the block; they must leave the state alone
  localparam logic [2:0] OP_UNDEF_6 = 3'd6;
  localparam logic [2:0] OP_UNDEF_7 = 3'd7;

  // Non-alphanumeric bytes next to the digit/letter ranges, plus 8'h80, 8'hFF and 8'h00
  localparam logic [7:0] EDGE_JUNK [9] = '{8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60,
                                           8'h7B, 8'h80, 8'hFF, 8'h00};

  logic clk;
  logic rst_n;

  bdq_in_if  in_ch ();
  bdq_out_if out_ch ();

  byte_deque_with_palindrome_check_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Deque mirror: own copy of the store and both end pointers.
  // front_ptr marks the empty slot before the oldest byte, back_ptr the
  // newest byte. Equal means empty; back+1 == front means full.
  // ---------------------------------------------------------------------
  logic [7:0] mirror_mem [QD];
  int         front_ptr = 0;
  int         back_ptr  = 0;

  bdq_pkg::out_item_t expected_q [$];   // results still owed by the block
  logic [7:0] word_buf [$];     // byte string being loaded into the deque

  int errors         = 0;
  int results_seen   = 0;
  int counted_items  = 0;       // transfers that do something (no 6/7 codes)
  int tx_idle_pct    = 12;
  int rx_idle_pct    = 77;
  int hold_requests  = 0;
  int cycle_count    = 0;

  function automatic int step_up(int i);
    return (i + 1) % QD;
  endfunction

  function automatic int step_down(int i);
    return (i + QD - 1) % QD;
  endfunction

  function automatic int fill_level();
    return (back_ptr + QD - front_ptr) % QD;
  endfunction

  function automatic bit is_alnum(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] fold_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // Walk inward from both ends, skipping non-alphanumerics; case-blind compare
  function automatic bit scan_palindrome();
    int lo;
    int hi;
    logic [7:0] a;
    logic [7:0] b;
    lo = front_ptr;
    hi = back_ptr;
    for (int g = 0; g <= QD; g++) begin
      if (lo == hi || step_up(lo) == hi) return 1'b1;
      a = fold_lower(mirror_mem[step_up(lo)]);
      b = fold_lower(mirror_mem[hi]);
      if (!is_alnum(a)) begin
        lo = step_up(lo);
      end else if (!is_alnum(b)) begin
        hi = step_down(hi);
      end else if (a != b) begin
        return 1'b0;
      end else begin
        lo = step_up(lo);
        hi = step_down(hi);
      end
    end
    return 1'b1;
  endfunction

  // Apply one operation to the mirror and return the result it owes
  function automatic bdq_pkg::out_item_t apply_op(logic [2:0] op, logic [7:0] d);
    bdq_pkg::out_item_t r;
    bit        empty;
    bit        full;
    r     = '0;
    empty = (front_ptr == back_ptr);
    full  = (step_up(back_ptr) == front_ptr);
    case (op)
      bdq_pkg::OP_ADD_REAR: begin
        if (full) begin
          r.status = bdq_pkg::STAT_FULL;
        end else begin
          back_ptr = step_up(back_ptr);
          mirror_mem[back_ptr] = d;
        end
      end
      bdq_pkg::OP_ADD_FRONT: begin
        if (full) begin
          r.status = bdq_pkg::STAT_FULL;
        end else begin
          mirror_mem[front_ptr] = d;
          front_ptr = step_down(front_ptr);
        end
      end
      bdq_pkg::OP_REM_FRONT: begin
        if (empty) begin
          r.read_byte = bdq_pkg::EMPTY_BYTE;
          r.status    = bdq_pkg::STAT_EMPTY;
        end else begin
          front_ptr   = step_up(front_ptr);
          r.read_byte = mirror_mem[front_ptr];
        end
      end
      bdq_pkg::OP_REM_REAR: begin
        if (empty) begin
          r.read_byte = bdq_pkg::EMPTY_BYTE;
          r.status    = bdq_pkg::STAT_EMPTY;
        end else begin
          r.read_byte = mirror_mem[back_ptr];
          back_ptr    = step_down(back_ptr);
        end
      end
      bdq_pkg::OP_CLEAR: begin
        // indices only; stored bytes stay
        front_ptr = 0;
        back_ptr  = 0;
      end
      bdq_pkg::OP_PAL_CHECK: r.palindrome_flag = scan_palindrome();
      default: ;
    endcase
    r.fill_count = 7'(fill_level());
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    errors++;
    $display("MISMATCH result %0d: %s", results_seen, msg);
  endtask

  // ---------------------------------------------------------------------
  // Sender: one operation per call. Gaps are drawn per cycle from the
  // current idle rate; valid stays high back to back when no gap is drawn.
  // Expectation is queued at the accepting edge. A pinned result replaces
  // the mirror's answer (the mirror still tracks the state change).
  // ---------------------------------------------------------------------
  task automatic issue_op(logic [2:0] op, logic [7:0] d, bit pinned = 1'b0,
                          bdq_pkg::out_item_t pinned_res = '0);
    bdq_pkg::out_item_t predicted;
    if (counted_items < TOTAL_ITEMS / 3) begin
      tx_idle_pct = 12;
      rx_idle_pct = 77;
    end else if (counted_items < 2 * TOTAL_ITEMS / 3) begin
      tx_idle_pct = 77;
      rx_idle_pct = 12;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.data.operation <= op;
    in_ch.data.data_byte <= d;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_op(op, d);
    expected_q.push_back(pinned ? pinned_res : predicted);
    if (op != OP_UNDEF_6 && op != OP_UNDEF_7) counted_items++;
  endtask

  function automatic logic [7:0] pick_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("a" + r - 10);
    return 8'("A" + r - 36);
  endfunction

  function automatic logic [7:0] pick_junk();
    logic [7:0] b;
    if ($urandom_range(0, 2) == 0) return EDGE_JUNK[$urandom_range(0, 8)];
    do b = 8'($urandom_range(0, 255)); while (is_alnum(b));
    return b;
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1))
      return c ^ 8'h20;
    return c;
  endfunction

  // Mirror-image string of len bytes: alphanumeric core, mixed case on each
  // side, junk bytes scattered anywhere. spoil swaps one alphanumeric byte.
  function automatic void build_mirror_word(int len, bit spoil);
    logic [7:0] half [$];
    int         junk;
    int         core;
    int         idx;
    junk = $urandom_range(0, len / 3);
    core = len - junk;
    word_buf.delete();
    for (int i = 0; i < core / 2; i++) half.push_back(pick_alnum());
    foreach (half[i]) word_buf.push_back(flip_case(half[i]));
    if (core % 2) word_buf.push_back(pick_alnum());
    for (int i = core / 2 - 1; i >= 0; i--) word_buf.push_back(flip_case(half[i]));
    repeat (junk) word_buf.insert($urandom_range(0, word_buf.size()), pick_junk());
    if (spoil && core > 0) begin
      do idx = $urandom_range(0, word_buf.size() - 1); while (!is_alnum(word_buf[idx]));
      word_buf[idx] = pick_alnum();
    end
  endfunction

  // Load word_buf so the deque reads it front to back: tail part by add rear,
  // head part by add front in reverse, split at a random point.
  task automatic load_word();
    int k;
    k = $urandom_range(0, word_buf.size());
    for (int i = k; i < word_buf.size(); i++) issue_op(bdq_pkg::OP_ADD_REAR, word_buf[i]);
    for (int i = k - 1; i >= 0; i--) issue_op(bdq_pkg::OP_ADD_FRONT, word_buf[i]);
  endtask

  task automatic drain_some(int n);
    repeat (n)
      issue_op($urandom_range(0, 1) ? bdq_pkg::OP_REM_FRONT : bdq_pkg::OP_REM_REAR,
               8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------
  // Directed rows: empty-queue removes and check, undefined codes, extreme
  // bytes, single-entry and junk-only checks, mixed case with digits, bytes
  // above 127, clear. Results pinned where obvious; the rest use the mirror.
  // ---------------------------------------------------------------------
  typedef struct {
    logic [2:0]         op;
    logic [7:0]         arg;
    bit                 pinned;
    bdq_pkg::out_item_t want;
  } directed_row_t;

  directed_row_t directed_rows [NUM_ROWS] = '{
    '{bdq_pkg::OP_REM_FRONT, 8'h00, 1'b1,
      '{bdq_pkg::EMPTY_BYTE, bdq_pkg::STAT_EMPTY, 1'b0, 7'd0}},
    '{bdq_pkg::OP_REM_REAR,  8'hFF, 1'b1,
      '{bdq_pkg::EMPTY_BYTE, bdq_pkg::STAT_EMPTY, 1'b0, 7'd0}},
    '{bdq_pkg::OP_PAL_CHECK, 8'h00, 1'b1, '{8'h00, bdq_pkg::STAT_OK, 1'b1, 7'd0}},
    '{OP_UNDEF_6,            8'hAA, 1'b1, '{8'h00, bdq_pkg::STAT_OK, 1'b0, 7'd0}},
    '{OP_UNDEF_7,            8'h55, 1'b1, '{8'h00, bdq_pkg::STAT_OK, 1'b0, 7'd0}},
    '{bdq_pkg::OP_ADD_REAR,  8'h00, 1'b1, '{8'h00, bdq_pkg::STAT_OK, 1'b0, 7'd1}},
    '{bdq_pkg::OP_PAL_CHECK, 8'h00, 1'b1, '{8'h00, bdq_pkg::STAT_OK, 1'b1, 7'd1}},
    '{bdq_pkg::OP_ADD_FRONT, 8'hFF, 1'b1, '{8'h00, bdq_pkg::STAT_OK, 1'b0, 7'd2}},
    '{bdq_pkg::OP_PAL_CHECK, 8'h00, 1'b1, '{8'h00, bdq_pkg::STAT_OK, 1'b1, 7'd2}},
    '{bdq_pkg::OP_REM_FRONT, 8'h00, 1'b1, '{8'hFF, bdq_pkg::STAT_OK, 1'b0, 7'd1}},
    '{bdq_pkg::OP_REM_REAR,  8'h00, 1'b1, '{8'h00, bdq_pkg::STAT_OK, 1'b0, 7'd0}},
    '{bdq_pkg::OP_ADD_REAR,  "A",   1'b0, '0},
    '{bdq_pkg::OP_ADD_REAR,  "b",   1'b0, '0},
    '{bdq_pkg::OP_ADD_FRONT, "B",   1'b0, '0},
    '{bdq_pkg::OP_PAL_CHECK, 8'h00, 1'b0, '0},
    '{bdq_pkg::OP_ADD_REAR,  "9",   1'b0, '0},
    '{bdq_pkg::OP_PAL_CHECK, 8'h00, 1'b0, '0},
    '{bdq_pkg::OP_ADD_FRONT, "9",   1'b0, '0},
    '{bdq_pkg::OP_ADD_FRONT, 8'hC1, 1'b0, '0},
    '{bdq_pkg::OP_ADD_REAR,  8'h5B, 1'b0, '0},
    '{bdq_pkg::OP_PAL_CHECK, 8'h00, 1'b0, '0},
    '{bdq_pkg::OP_ADD_REAR,  "z",   1'b0, '0},
    '{bdq_pkg::OP_PAL_CHECK, 8'h00, 1'b0, '0},
    '{bdq_pkg::OP_CLEAR,     8'h00, 1'b1, '{8'h00, bdq_pkg::STAT_OK, 1'b0, 7'd0}},
    '{bdq_pkg::OP_PAL_CHECK, 8'h00, 1'b1, '{8'h00, bdq_pkg::STAT_OK, 1'b1, 7'd0}}
  };

  // ---------------------------------------------------------------------
  // Receiver: per-cycle stalls at the current rate; a hold request turns
  // into HOLD_CYCLES of ready low, so the output register fills and the
  // block stops taking transfers while the sender keeps offering.
  // ---------------------------------------------------------------------
  initial begin : result_ready_drive
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Result check: every transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    bdq_pkg::out_item_t got;
    bdq_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      results_seen++;
      if (expected_q.size() == 0) begin
        note_mismatch("result transfer with no expectation waiting");
      end else begin
        want = expected_q.pop_front();
        if (got.read_byte !== want.read_byte)
          note_mismatch($sformatf("read_byte %0h, expected %0h",
                                  got.read_byte, want.read_byte));
        if (got.status !== want.status)
          note_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.palindrome_flag !== want.palindrome_flag)
          note_mismatch($sformatf("palindrome_flag %0b, expected %0b",
                                  got.palindrome_flag, want.palindrome_flag));
        if (got.fill_count !== want.fill_count)
          note_mismatch($sformatf("fill_count %0d, expected %0d",
                                  got.fill_count, want.fill_count));
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("byte_deque_with_palindrome_check_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    bit mirror_fill_done;
    bit random_fill_done;
    int len;
    mirror_fill_done = 1'b0;
    random_fill_done = 1'b0;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      issue_op(directed_rows[i].op, directed_rows[i].arg,
               directed_rows[i].pinned, directed_rows[i].want);

    while (counted_items < TOTAL_ITEMS) begin
      if (!mirror_fill_done && counted_items >= 150) begin
        // Full mirror-image queue under a long receiver stall; pushes past
        // full must be dropped; then a check walk over the full queue
        mirror_fill_done = 1'b1;
        issue_op(bdq_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
        hold_requests++;
        build_mirror_word(QD - 1, 1'b0);
        load_word();
        issue_op(bdq_pkg::OP_ADD_REAR, pick_alnum());
        issue_op(bdq_pkg::OP_ADD_FRONT, pick_junk());
        issue_op(bdq_pkg::OP_PAL_CHECK, 8'($urandom_range(0, 255)));
        drain_some(8);
        issue_op(bdq_pkg::OP_PAL_CHECK, 8'($urandom_range(0, 255)));
        issue_op(bdq_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
      end else if (!random_fill_done && counted_items >= 400) begin
        // Fill with raw bytes from wherever the pointers are, back to back
        random_fill_done = 1'b1;
        while (fill_level() < QD - 1)
          issue_op($urandom_range(0, 1) ? bdq_pkg::OP_ADD_REAR : bdq_pkg::OP_ADD_FRONT,
                   8'($urandom_range(0, 255)));
        repeat (2)
          issue_op($urandom_range(0, 1) ? bdq_pkg::OP_ADD_REAR : bdq_pkg::OP_ADD_FRONT,
                   8'($urandom_range(0, 255)));
        issue_op(bdq_pkg::OP_PAL_CHECK, 8'($urandom_range(0, 255)));
        drain_some(20);
      end else if ($urandom_range(0, 99) < 60) begin
        // Well-formed: load a (maybe spoiled) mirror word, check, unload some
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        if ($urandom_range(0, 3) != 0)
          issue_op(bdq_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
        build_mirror_word(len, $urandom_range(0, 3) == 0);
        load_word();
        issue_op(bdq_pkg::OP_PAL_CHECK, 8'($urandom_range(0, 255)));
        drain_some($urandom_range(0, fill_level() + 1));
        if ($urandom_range(0, 1))
          issue_op(bdq_pkg::OP_PAL_CHECK, 8'($urandom_range(0, 255)));
      end else begin
        // Noise: any code, any byte
        repeat ($urandom_range(1, 8))
          issue_op(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("byte_deque_with_palindrome_check_unit test passed");
    end else begin
      $display("byte_deque_with_palindrome_check_unit test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_in_if.sv
hw/rtl/bdq_out_if.sv
hw/rtl/byte_deque_with_palindrome_check_unit.sv
tb/byte_deque_with_palindrome_check_unit_test.sv
